// File: rtl/ckhs_pkg.sv
// shared constants, types and helpers for the canonical k-mer hash sampler
package ckhs_pkg;

   localparam int MAX_K_DEF  = 42;
   localparam int KLEN_W     = 6;
   localparam int DATA_W     = 64;
   localparam int CODE_W     = 3;
   localparam int CSR_IDX_W  = 2;
   localparam int MID_DEPTH  = 2;
   localparam int OUT_DEPTH  = 8;

   localparam logic [DATA_W-1:0] MIX_A = 64'hff51afd7ed558ccd;
   localparam logic [DATA_W-1:0] MIX_B = 64'hc4ceb9fe1a85ec53;

   localparam logic [KLEN_W-1:0] KMER_LENGTH_RST  = 6'd21;
   localparam logic [DATA_W-1:0] MIX_SEED_RST     = 64'd42;
   localparam logic [DATA_W-1:0] SAMPLE_LIMIT_RST = 64'd1844674407370955161;

   localparam logic [CSR_IDX_W-1:0] CSR_KMER_LENGTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_SEED     = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SAMPLE_LIMIT = 2'd2;

   localparam logic [CODE_W-1:0] CODE_NONE = 3'd0;
   localparam logic [CODE_W-1:0] CODE_A    = 3'd1;
   localparam logic [CODE_W-1:0] CODE_C    = 3'd6;
   localparam logic [CODE_W-1:0] CODE_G    = 3'd3;
   localparam logic [CODE_W-1:0] CODE_T    = 3'd4;

   typedef logic [CODE_W-1:0] code_type;

   function automatic code_type base_code(input logic [7:0] c);
      code_type r;
      case (c)
         "A", "a": r = CODE_A;
         "C", "c": r = CODE_C;
         "G", "g": r = CODE_G;
         "T", "t": r = CODE_T;
         default:  r = CODE_NONE;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/ckhs_queue.sv
// small first-word-fall-through queue built from registers
module ckhs_queue
   import ckhs_pkg::*;
#(
   parameter int DEPTH = MID_DEPTH,
   parameter int WIDTH = DATA_W
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: rtl/ckhs_front.sv
// front end: base decode, k-mer shift register, valid count and hash request
module ckhs_front
   import ckhs_pkg::*;
#(
   parameter int MAX_K = MAX_K_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          beat,
   input  logic [7:0]                    base_char,
   input  logic                          window_start,
   input  logic [KLEN_W-1:0]             kmer_length,
   output logic                          mq_push,
   output logic [KLEN_W+3*MAX_K-1:0]     mq_data
);

   localparam int W     = 3 * MAX_K;
   localparam int CNT_W = $clog2(MAX_K + 1);
   localparam logic [CNT_W-1:0]  CNT_MAX = CNT_W'(MAX_K);
   localparam logic [KLEN_W-1:0] K_MAX   = KLEN_W'(MAX_K);

   logic [W-1:0]      win_ff, win_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [W-1:0]      base_win;
   logic [CNT_W-1:0]  base_cnt;
   logic [KLEN_W-1:0] k_eff;
   code_type          code;

   always_comb begin
      if (kmer_length == '0) begin
         k_eff = KLEN_W'(1);
      end else if (kmer_length > K_MAX) begin
         k_eff = K_MAX;
      end else begin
         k_eff = kmer_length;
      end
   end

   always_comb begin
      code     = base_code(base_char);
      base_win = window_start ? '0 : win_ff;
      base_cnt = window_start ? '0 : cnt_ff;
      win_in   = win_ff;
      cnt_in   = cnt_ff;
      mq_push  = 1'b0;
      if (beat) begin
         if (code == CODE_NONE) begin
            win_in = '0;
            cnt_in = '0;
         end else begin
            // newest code enters at the low end
            win_in  = W'({base_win, code});
            cnt_in  = (base_cnt == CNT_MAX) ? base_cnt : base_cnt + CNT_W'(1);
            mq_push = (7'(cnt_in) >= 7'(k_eff));
         end
      end
      mq_data = {k_eff, win_in};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff <= '0;
         cnt_ff <= '0;
      end else begin
         win_ff <= win_in;
         cnt_ff <= cnt_in;
      end
   end

endmodule

// File: rtl/ckhs_back.sv
// back end: canonical k-mer, 128x64 seed mix, fold and threshold, credit count
module ckhs_back
   import ckhs_pkg::*;
#(
   parameter int MAX_K     = MAX_K_DEF,
   parameter int OUT_SLOTS = OUT_DEPTH
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      mq_empty,
   input  logic [KLEN_W+3*MAX_K-1:0] mq_data,
   output logic                      mq_pop,
   input  logic [DATA_W-1:0]         mix_seed,
   input  logic [DATA_W-1:0]         sample_limit,
   input  logic                      out_pop,
   output logic                      res_push,
   output logic [DATA_W-1:0]         res_hash
);

   localparam int W    = 3 * MAX_K;
   localparam int CR_W = $clog2(OUT_SLOTS + 1);
   localparam logic [CR_W-1:0] CR_MAX = CR_W'(OUT_SLOTS);
   localparam logic [7:0]      W8     = 8'(W);

   logic [CR_W-1:0]   inflight_ff, inflight_in;
   logic              issue, drop;

   logic [KLEN_W-1:0] k;
   logic [7:0]        k3;
   logic [W-1:0]      win, win_rev, fwd, rev;

   logic              s1_v_ff, s2_v_ff, s3_v_ff, s4_v_ff, s5_v_ff;
   logic [127:0]      s1_fwd_ff, s1_rev_ff;
   logic [127:0]      canon;
   logic [DATA_W-1:0] s2_a_ff, s2_c_ff;
   logic [DATA_W-1:0] seed_mix;
   logic [63:0]       s3_p00_ff, s3_p01_ff, s3_p10_ff, s3_p11_ff, s3_c00_ff;
   logic [31:0]       s3_c01_ff, s3_c10_ff;
   logic [63:0]       s4_lo_ff, s4_hi_ff;
   logic [64:0]       s4_mid_ff;
   logic [31:0]       s4_top_ff;
   logic [127:0]      s5_p_ff;

   assign issue  = !mq_empty && (inflight_ff < CR_MAX);
   assign mq_pop = issue;

   // window and reverse complement for the first k bases
   always_comb begin
      k   = mq_data[W+KLEN_W-1:W];
      win = mq_data[W-1:0];
      k3  = {1'b0, k, 1'b0} + {2'b00, k};
      for (int i = 0; i < W; i++) begin
         win_rev[i] = win[W-1-i];
      end
      fwd = win & ~({W{1'b1}} << k3);
      rev = win_rev >> (W8 - k3);
   end

   assign canon    = (s1_fwd_ff < s1_rev_ff) ? s1_fwd_ff : s1_rev_ff;
   assign seed_mix = mix_seed ^ MIX_B;

   always_ff @(posedge clock) begin
      s1_fwd_ff <= 128'(fwd);
      s1_rev_ff <= 128'(rev);

      s2_a_ff <= canon[63:0] ^ MIX_A;
      s2_c_ff <= canon[127:64];

      // partial products; the high word of canon only matters mod 2^64
      s3_p00_ff <= s2_a_ff[31:0]  * seed_mix[31:0];
      s3_p01_ff <= s2_a_ff[31:0]  * seed_mix[63:32];
      s3_p10_ff <= s2_a_ff[63:32] * seed_mix[31:0];
      s3_p11_ff <= s2_a_ff[63:32] * seed_mix[63:32];
      s3_c00_ff <= s2_c_ff[31:0]  * seed_mix[31:0];
      s3_c01_ff <= 32'(s2_c_ff[31:0]  * seed_mix[63:32]);
      s3_c10_ff <= 32'(s2_c_ff[63:32] * seed_mix[31:0]);

      s4_lo_ff  <= s3_p00_ff;
      s4_mid_ff <= 65'(s3_p01_ff) + 65'(s3_p10_ff);
      s4_hi_ff  <= s3_p11_ff + s3_c00_ff;
      s4_top_ff <= s3_c01_ff + s3_c10_ff;

      s5_p_ff <= 128'(s4_lo_ff) + (128'(s4_mid_ff) << 32) + {s4_hi_ff, 64'd0}
                 + {s4_top_ff, 96'd0};
   end

   assign res_hash = s5_p_ff[63:0] ^ s5_p_ff[127:64];
   assign res_push = s5_v_ff && (res_hash < sample_limit);
   assign drop     = s5_v_ff && !res_push;

   // slots are reserved at issue, so the result queue never overflows
   assign inflight_in = inflight_ff + CR_W'(issue) - CR_W'(drop) - CR_W'(out_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         s4_v_ff     <= 1'b0;
         s5_v_ff     <= 1'b0;
         inflight_ff <= '0;
      end else begin
         s1_v_ff     <= issue;
         s2_v_ff     <= s1_v_ff;
         s3_v_ff     <= s2_v_ff;
         s4_v_ff     <= s3_v_ff;
         s5_v_ff     <= s4_v_ff;
         inflight_ff <= inflight_in;
      end
   end

endmodule

// File: rtl/canonical_kmer_hash_sampler_top.sv
// Canonical k-mer hash sampler: one nucleotide byte per beat in, one 64-bit hash per
// sampled k-mer out. The front end takes a base every cycle while the two-entry queue
// is not full and keeps the k-mer window; each full window goes through that queue to
// a five-stage back end (reverse complement, canonical pick, 32x32 partial products,
// two add stages) whose fold and threshold compare feed the result queue. Sustained
// rate is one base per cycle as long as results are popped; the eight-entry result
// queue and the credit count that reserves its slots set how far the pipe runs ahead
// of a stalled consumer. Configuration must be written only while idle; the block
// itself does not enforce it.
module canonical_kmer_hash_sampler_top
   import ckhs_pkg::*;
#(
   parameter int MAX_K = MAX_K_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_base_char,
   input  logic                 req_window_start,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [DATA_W-1:0]    rsp_sketch_hash,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [DATA_W-1:0]    csr_wdata
);

   localparam int MQ_W = KLEN_W + 3 * MAX_K;

   logic [KLEN_W-1:0] kmer_length_ff;
   logic [DATA_W-1:0] mix_seed_ff, sample_limit_ff;

   logic              req_beat, rsp_beat;
   logic              mq_push, mq_pop, mq_empty;
   logic [MQ_W-1:0]   mq_wdata, mq_rdata;
   logic              res_push;
   logic [DATA_W-1:0] res_hash;

   assign req_beat = req_push && !req_full;
   assign rsp_beat = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         kmer_length_ff  <= KMER_LENGTH_RST;
         mix_seed_ff     <= MIX_SEED_RST;
         sample_limit_ff <= SAMPLE_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_KMER_LENGTH:  kmer_length_ff  <= csr_wdata[KLEN_W-1:0];
            CSR_MIX_SEED:     mix_seed_ff     <= csr_wdata;
            CSR_SAMPLE_LIMIT: sample_limit_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   ckhs_front #(.MAX_K(MAX_K)) u_front (
      .clock        (clock),
      .reset        (reset),
      .beat         (req_beat),
      .base_char    (req_base_char),
      .window_start (req_window_start),
      .kmer_length  (kmer_length_ff),
      .mq_push      (mq_push),
      .mq_data      (mq_wdata)
   );

   ckhs_queue #(.DEPTH(MID_DEPTH), .WIDTH(MQ_W)) u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (mq_push),
      .push_data (mq_wdata),
      .full      (req_full),
      .pop       (mq_pop),
      .pop_data  (mq_rdata),
      .empty     (mq_empty)
   );

   ckhs_back #(.MAX_K(MAX_K), .OUT_SLOTS(OUT_DEPTH)) u_back (
      .clock        (clock),
      .reset        (reset),
      .mq_empty     (mq_empty),
      .mq_data      (mq_rdata),
      .mq_pop       (mq_pop),
      .mix_seed     (mix_seed_ff),
      .sample_limit (sample_limit_ff),
      .out_pop      (rsp_beat),
      .res_push     (res_push),
      .res_hash     (res_hash)
   );

   ckhs_queue #(.DEPTH(OUT_DEPTH), .WIDTH(DATA_W)) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_hash),
      .full      (),
      .pop       (rsp_pop),
      .pop_data  (rsp_sketch_hash),
      .empty     (rsp_empty)
   );

endmodule

// File: rtl/ckhs_checker.sv
// port-level checks for the sampler, bound to the top level
module ckhs_checker
   import ckhs_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_push,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input logic [DATA_W-1:0] rsp_sketch_hash
);

   // after reset the result queue is empty and the front queue is not full
   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   // the front queue fills only through an input beat
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      $rose(req_full) |-> $past(req_push))
      else $error("full rose without a push");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty)
      else $error("waiting result vanished");

   a_result_stable: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> $stable(rsp_sketch_hash))
      else $error("waiting result changed");

endmodule

bind canonical_kmer_hash_sampler_top ckhs_checker u_checker (.*);
